// ----- design/i2cscq_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cscq_pkg
// Shared types, constants and helpers for the I2C slave command queue:
// event codes, bus phases, ring sizing and the result beat bit layout.
// ----------------------------------------------------------------------------
package i2cscq_pkg;

  // ring of pairs, one slot kept free to tell full from empty
  localparam int QUEUE_DEPTH     = 8;
  localparam int PTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  // read-command table, one byte per entry
  localparam int READ_TABLE_SIZE = 8;
  localparam int LIST_W          = 64;

  typedef logic [PTR_W-1:0] ptr_t;

  // decoded bus event codes carried in the input beat
  localparam logic [2:0] EV_ADDR_WRITE = 3'd0;
  localparam logic [2:0] EV_DATA_ACK   = 3'd1;
  localparam logic [2:0] EV_DATA_NACK  = 3'd2;
  localparam logic [2:0] EV_STOP       = 3'd3;
  localparam logic [2:0] EV_ADDR_READ  = 3'd4;
  localparam logic [2:0] EV_TX_DONE    = 3'd5;
  localparam logic [2:0] EV_OTHER      = 3'd6;
  localparam logic [2:0] EV_POP        = 3'd7;

  // slave transaction phase
  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_WAIT_CODE = 6'b000010,
    PH_GOT_CODE  = 6'b000100,
    PH_GOT_ARG   = 6'b001000,
    PH_READ_REQ  = 6'b010000,
    PH_SENT      = 6'b100000
  } phase_t;

  // input tuser layout, lowest bit up
  localparam int IN_CMD_LSB     = 0;
  localparam int IN_SET_RES_BIT = 3;

  // result tuser layout, lowest bit up
  localparam int OUT_ACK_BIT      = 0;
  localparam int OUT_POP_BIT      = 1;
  localparam int OUT_IS_READ_BIT  = 2;
  localparam int OUT_NONEMPTY_BIT = 3;

  // ring pointer increment with wrap at the depth
  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) n = '0;
    else                              n = p + 1'b1;
    return n;
  endfunction

  // command byte lookup in the zero-terminated read-command table
  function automatic logic code_in_table(input logic [LIST_W-1:0] list,
                                         input logic [7:0] code);
    logic       hit;
    logic       live;
    logic [7:0] entry;
    hit  = 1'b0;
    live = 1'b1;
    for (int i = 0; i < READ_TABLE_SIZE; i++) begin
      entry = list[8*i +: 8];
      if (entry == 8'h00) begin
        live = 1'b0;
      end else if (live && (entry == code)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ----- design/i2c_slave_command_queue.sv -----
// ----------------------------------------------------------------------------
// i2c_slave_command_queue
// Command front end of an I2C slave: turns decoded bus events into ACK/NACK
// decisions, queues command/argument pairs and serves local pops.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | tdata: rx_byte, new_result   tuser: cmd, set_result
//  m_*     | out       | tdata: tx_byte, cmd_code, cmd_arg
//          |           | tuser: ack, pop_valid, cmd_is_read, queue_nonempty
//  cfg_*   | in        | read_command_list, 64 bits
//
//  one beat per cycle sustained while m_tready is high; a result beat passes
//  through the input register, then the result register
//  the state update of each beat happens in one pass of logic between them
//  rst is synchronous; no clearing pass, ring slots hold unknown data
//  a stalled result register holds the input register, which backs s_tready
module i2c_slave_command_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [7:0] rx_byte, [15:8] new_result
  input  logic [3:0]  s_tuser,    // [2:0] cmd, [3] set_result
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] tx_byte, [15:8] cmd_code, [23:16] cmd_arg
  output logic [3:0]  m_tuser,    // [0] ack, [1] pop_valid, [2] cmd_is_read,
                                  // [3] queue_nonempty
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [i2cscq_pkg::LIST_W-1:0] cfg_data
);
  import i2cscq_pkg::*;

  // input register
  logic        in_valid;
  logic [2:0]  in_cmd;
  logic [7:0]  in_rx;
  logic        in_set_res;
  logic [7:0]  in_new_res;

  // block state
  logic [LIST_W-1:0] cmd_list;
  phase_t            phase, phase_next;
  logic [7:0]        pending_code, pending_code_next;
  logic [15:0]       pair_store [QUEUE_DEPTH];
  ptr_t              read_ptr, read_ptr_next;
  ptr_t              write_ptr, write_ptr_next;
  logic [7:0]        result_hold, result_hold_next;

  // result values of the current beat
  logic        store_we;
  logic        r_ack, r_pop, r_is_read, r_nonempty;
  logic [7:0]  r_tx, r_code, r_arg;
  logic [15:0] head_pair;
  ptr_t        head_ptr_next;
  logic        full, empty, advance;

  // result register
  logic        out_valid;
  logic [23:0] out_data;
  logic [3:0]  out_user;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign m_tuser   = out_user;

  assign full          = (read_ptr == ring_next(write_ptr));
  assign empty         = (read_ptr == write_ptr);
  assign head_ptr_next = advance ? read_ptr_next : read_ptr;

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_cmd     <= s_tuser[IN_CMD_LSB +: 3];
      in_set_res <= s_tuser[IN_SET_RES_BIT];
      in_rx      <= s_tdata[7:0];
      in_new_res <= s_tdata[15:8];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_list <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cmd_list <= cfg_data;
    end
  end

  // event decode and next state
  always_comb begin
    phase_next        = phase;
    pending_code_next = pending_code;
    read_ptr_next     = read_ptr;
    write_ptr_next    = write_ptr;
    result_hold_next  = result_hold;
    store_we          = 1'b0;
    r_ack             = 1'b0;
    r_tx              = 8'h00;
    r_pop             = 1'b0;
    r_code            = 8'h00;
    r_arg             = 8'h00;
    r_is_read         = 1'b0;
    unique case (in_cmd)
      EV_ADDR_WRITE: begin
        if (full) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_WAIT_CODE;
          r_ack      = 1'b1;
        end
      end
      EV_DATA_ACK: begin
        unique case (phase)
          PH_WAIT_CODE: begin
            if (in_rx != 8'h00) begin
              pending_code_next = in_rx;
              phase_next        = PH_GOT_CODE;
              r_ack             = 1'b1;
            end else begin
              // ping: zero command byte
              phase_next = PH_IDLE;
            end
          end
          PH_GOT_CODE: begin
            if (!full) begin
              store_we       = 1'b1;
              write_ptr_next = ring_next(write_ptr);
              r_ack          = 1'b1;
            end
            pending_code_next = 8'h00;
            phase_next        = PH_GOT_ARG;
          end
          default: begin
            // surplus data byte: NACK, keep state
          end
        endcase
      end
      EV_DATA_NACK: begin
      end
      EV_STOP: begin
        phase_next = PH_IDLE;
        r_ack      = 1'b1;
      end
      EV_ADDR_READ: begin
        phase_next       = PH_READ_REQ;
        r_tx             = result_hold;
        result_hold_next = 8'h00;
      end
      EV_TX_DONE: begin
        phase_next = PH_SENT;
      end
      EV_OTHER: begin
        phase_next        = PH_IDLE;
        pending_code_next = 8'h00;
        r_ack             = 1'b1;
      end
      EV_POP: begin
        if (!empty) begin
          read_ptr_next = ring_next(read_ptr);
          r_pop         = 1'b1;
          r_code        = head_pair[15:8];
          r_arg         = head_pair[7:0];
          r_is_read     = code_in_table(cmd_list, head_pair[15:8]);
        end
      end
      default: begin
      end
    endcase
    if (in_set_res) begin
      result_hold_next = in_new_res;
    end
    r_nonempty = (read_ptr_next != write_ptr_next);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pending_code <= 8'h00;
      read_ptr     <= '0;
      write_ptr    <= '0;
      result_hold  <= 8'h00;
    end else if (advance) begin
      phase        <= phase_next;
      pending_code <= pending_code_next;
      read_ptr     <= read_ptr_next;
      write_ptr    <= write_ptr_next;
      result_hold  <= result_hold_next;
    end
  end

  // pair ring storage, oldest pair kept in a register with write bypass
  always_ff @(posedge clk) begin
    if (advance && store_we) begin
      pair_store[write_ptr] <= {pending_code, in_rx};
    end
    if (advance && store_we && (write_ptr == head_ptr_next)) begin
      head_pair <= {pending_code, in_rx};
    end else begin
      head_pair <= pair_store[head_ptr_next];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data                   <= {r_arg, r_code, r_tx};
      out_user[OUT_ACK_BIT]      <= r_ack;
      out_user[OUT_POP_BIT]      <= r_pop;
      out_user[OUT_IS_READ_BIT]  <= r_is_read;
      out_user[OUT_NONEMPTY_BIT] <= r_nonempty;
    end
  end

endmodule

// ----- design/i2cscq_checker.sv -----
// ----------------------------------------------------------------------------
// i2cscq_checker
// Port-level checks on the result beats of the I2C slave command queue.
// ----------------------------------------------------------------------------
module i2cscq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [3:0]  m_tuser
);
  import i2cscq_pkg::*;

  // a pop never acknowledges a bus event
  a_pop_no_ack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[OUT_POP_BIT] |-> !m_tuser[OUT_ACK_BIT])
    else $error("pop beat carries ack");

  // read-command flag only on a real pop
  a_isread_pop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[OUT_IS_READ_BIT] |-> m_tuser[OUT_POP_BIT])
    else $error("read flag without popped pair");

  // pair fields zero unless a pair was popped
  a_pair_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[OUT_POP_BIT] |-> (m_tdata[23:8] == 16'h0000))
    else $error("pair fields set without pop");

  // a popped command byte is never zero
  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[OUT_POP_BIT] |-> (m_tdata[15:8] != 8'h00))
    else $error("popped zero command byte");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

endmodule

bind i2c_slave_command_queue i2cscq_checker u_i2cscq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
